// ===== src/tced_pkg.sv =====
// shared types and constants of the two-car elevator dispatcher
`default_nettype none

package tced_pkg;

    // floor numbers and scan indexes are four bits wide
    localparam int FLOOR_W   = 4;
    localparam int CFG_IDX_W = 2;

    typedef logic [FLOOR_W-1:0] t_floor;

    // request function codes
    localparam logic [1:0] FUNC_CALL   = 2'd0;
    localparam logic [1:0] FUNC_TICK   = 2'd1;
    localparam logic [1:0] FUNC_EXPIRE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPLIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_B = 2'd2;

    // configuration reset values
    localparam t_floor SPLIT_RST  = 4'd4;
    localparam t_floor HOME_A_RST = 4'd1;
    localparam t_floor HOME_B_RST = 4'd6;

    // car heading codes
    localparam logic signed [1:0] DIR_IDLE = 2'sb00;
    localparam logic signed [1:0] DIR_UP   = 2'sb01;
    localparam logic signed [1:0] DIR_DN   = 2'sb11;

    typedef enum logic [2:0] {
        OUT_IGNORED,
        OUT_QUEUED,
        OUT_PASSING,
        OUT_MOVED,
        OUT_PAUSED,
        OUT_REACHED
    } t_outcome;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CALL,
        S_TICK,
        S_EXP,
        S_XSCAN,
        S_XCHK,
        S_NSCAN,
        S_PICK,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        TBL_NONE,
        TBL_INC,
        TBL_DEC
    } t_tbl_op;

    // one access to the call count tables
    typedef struct packed {
        t_tbl_op op;
        logic    car;
        logic    up;
        t_floor  floor;
    } t_tbl_req;

    // nonzero flags of the addressed up and down entries
    typedef struct packed {
        logic up_nz;
        logic dn_nz;
    } t_tbl_rsp;

    typedef struct packed {
        logic start;
        logic step;
    } t_scan_ctl;

    // lowest pending up floor and highest pending down floor
    typedef struct packed {
        logic   up_hit;
        t_floor up_floor;
        logic   dn_hit;
        t_floor dn_floor;
    } t_scan_res;

endpackage

`default_nettype wire

// ===== src/two_car_elevator_dispatcher.sv =====
// top level of the two-car elevator dispatcher: sequencer, car state and configuration
`default_nettype none

// Dispatches hall calls between two cars and steps the cars on move ticks. One request is
// taken at a time: o_ready is high only while the block waits for a request, and each request
// gives exactly one result. A tick short of its target, a call to a busy car and an ignored
// call or expiry need no floor scan, and an unused function code goes straight to its
// result; a request that makes a car pick its next target (a call to an idle car, a tick
// that reaches the target) runs a floor scan of the call count tables, one floor per cycle,
// and an idle-return expiry that issues its call runs one or two such scans. The block is
// ready again in the cycle after the result transfer. Configuration writes are taken at any
// edge out of reset with i_cfg_we high and are meant for times when no request is in flight.
module two_car_elevator_dispatcher #(
    parameter int NUM_FLOORS  = 9,
    parameter int COUNT_WIDTH = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_func,
    input  logic                              i_car_sel,
    input  tced_pkg::t_floor                  i_call_floor,
    input  logic                              i_going_up,
    // result channel
    output logic                              o_valid,
    input  logic                              i_ready,
    output tced_pkg::t_floor                  o_car_a_floor,
    output tced_pkg::t_floor                  o_car_b_floor,
    output tced_pkg::t_floor                  o_car_a_target,
    output tced_pkg::t_floor                  o_car_b_target,
    output logic                              o_car_a_moving,
    output logic                              o_car_b_moving,
    output logic signed [1:0]                 o_car_a_heading,
    output logic signed [1:0]                 o_car_b_heading,
    output logic                              o_assigned_car,
    output logic [2:0]                        o_outcome,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [tced_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  tced_pkg::t_floor                  i_cfg_wdata
);
    import tced_pkg::*;

    localparam int FIDX_W = (NUM_FLOORS > 1) ? $clog2(NUM_FLOORS) : 1;
    localparam logic [FLOOR_W:0] NF = (FLOOR_W + 1)'(NUM_FLOORS);
    localparam t_floor TOP_FLOOR = FLOOR_W'(NUM_FLOORS - 1);
    localparam t_floor RST_POS_A = (int'(HOME_A_RST) < NUM_FLOORS) ? HOME_A_RST : TOP_FLOOR;
    localparam t_floor RST_POS_B = (int'(HOME_B_RST) < NUM_FLOORS) ? HOME_B_RST : TOP_FLOOR;

    // sequencer
    t_state r_state;
    t_state n_state;

    // request and result registers
    logic     r_csel, n_csel;
    t_floor   r_cf, n_cf;
    logic     r_cup, n_cup;
    logic     r_scar, n_scar;
    logic     r_who, n_who;
    t_outcome r_outcome, n_outcome;

    // car state
    t_floor                  r_pos   [2];
    t_floor                  n_pos   [2];
    t_floor                  r_tgt   [2];
    t_floor                  n_tgt   [2];
    logic signed [1:0]       r_dir   [2];
    logic signed [1:0]       n_dir   [2];
    logic                    r_busy  [2];
    logic                    n_busy  [2];
    logic [NUM_FLOORS-1:0]   r_mask  [2];
    logic [NUM_FLOORS-1:0]   n_mask  [2];
    logic                    r_armed [2];
    logic                    n_armed [2];

    // configuration
    t_floor r_split;
    t_floor r_home_a;
    t_floor r_home_b;

    // table and scan interfaces
    t_tbl_req  w_tbl_req;
    t_tbl_rsp  w_tbl_rsp;
    t_scan_ctl w_scan_ctl;
    t_scan_res w_sres;
    t_floor    w_scan_idx;
    logic      w_scan_last;

    // working values
    logic              w_car;
    logic              w_pref;
    logic              w_pref_busy;
    logic              w_choice;
    t_floor            w_da;
    t_floor            w_db;
    t_floor            w_pos;
    t_floor            w_tgt;
    logic signed [1:0] w_dir;
    logic              w_busy;
    logic [NUM_FLOORS-1:0] w_mask;
    logic              w_armed;
    logic [FIDX_W-1:0] w_pos_idx;
    logic [FIDX_W-1:0] w_cf_idx;
    logic              w_out_range;
    logic              w_pass;
    logic              w_stop;
    logic              w_empty;
    logic              w_pick_up;
    t_floor            w_pick_f;

    tced_tables #(
        .NUM_FLOORS  (NUM_FLOORS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_tables (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_tbl_req),
        .o_rsp   (w_tbl_rsp)
    );

    tced_scan #(
        .NUM_FLOORS (NUM_FLOORS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_scan_ctl),
        .i_rsp   (w_tbl_rsp),
        .o_idx   (w_scan_idx),
        .o_last  (w_scan_last),
        .o_res   (w_sres)
    );

    // car choice for a hall call: split floor, then idle car, then nearer car
    assign w_da = (r_pos[0] > r_cf) ? (r_pos[0] - r_cf) : (r_cf - r_pos[0]);
    assign w_db = (r_pos[1] > r_cf) ? (r_pos[1] - r_cf) : (r_cf - r_pos[1]);
    assign w_pref      = (r_cf > r_split);
    assign w_pref_busy = w_pref ? r_busy[1] : r_busy[0];

    always_comb begin
        if (w_pref_busy) begin
            if (!r_busy[0] && r_busy[1]) begin
                w_choice = 1'b0;
            end else if (r_busy[0] && !r_busy[1]) begin
                w_choice = 1'b1;
            end else begin
                w_choice = (w_da > w_db);
            end
        end else begin
            w_choice = w_pref;
        end
    end

    // car that the current step works on
    always_comb begin
        case (r_state)
            S_CALL:                 w_car = w_choice;
            S_TICK, S_EXP, S_XCHK:  w_car = r_csel;
            default:                w_car = r_scar;
        endcase
    end

    assign w_pos     = r_pos[w_car];
    assign w_tgt     = r_tgt[w_car];
    assign w_dir     = r_dir[w_car];
    assign w_busy    = r_busy[w_car];
    assign w_mask    = r_mask[w_car];
    assign w_armed   = r_armed[w_car];
    assign w_pos_idx = w_pos[FIDX_W-1:0];
    assign w_cf_idx  = r_cf[FIDX_W-1:0];

    assign w_out_range = ({1'b0, r_cf} >= NF);
    assign w_stop      = w_mask[w_pos_idx];

    // call in the direction of travel strictly between car and target
    assign w_pass = ((w_dir == DIR_UP) && r_cup && (r_cf > w_pos) && (r_cf < w_tgt)) ||
                    ((w_dir == DIR_DN) && !r_cup && (r_cf < w_pos) && (r_cf > w_tgt));

    // next target selection from the scan result
    assign w_empty   = !w_sres.up_hit && !w_sres.dn_hit;
    assign w_pick_up = (w_dir == DIR_UP) ? w_sres.up_hit : !w_sres.dn_hit;
    assign w_pick_f  = w_pick_up ? w_sres.up_floor : w_sres.dn_floor;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_func)
                        FUNC_CALL:   n_state = S_CALL;
                        FUNC_TICK:   n_state = S_TICK;
                        FUNC_EXPIRE: n_state = S_EXP;
                        default:     n_state = S_DONE;
                    endcase
                end
            end
            S_CALL: begin
                if (w_out_range || w_busy) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_NSCAN;
                end
            end
            S_TICK: begin
                if (w_busy && !w_stop && (w_pos == w_tgt)) begin
                    n_state = S_NSCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_EXP: begin
                if (w_armed && !w_busy && (w_dir == DIR_IDLE)) begin
                    n_state = S_XSCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_XSCAN: begin
                if (w_scan_last) begin
                    n_state = S_XCHK;
                end
            end
            S_XCHK: begin
                n_state = w_empty ? S_CALL : S_DONE;
            end
            S_NSCAN: begin
                if (w_scan_last) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // scan control: start on entry, one floor per cycle while scanning
    assign w_scan_ctl.step  = (r_state == S_NSCAN) || (r_state == S_XSCAN);
    assign w_scan_ctl.start = ((n_state == S_NSCAN) || (n_state == S_XSCAN)) &&
                              !w_scan_ctl.step;

    // datapath updates, table accesses and result
    always_comb begin
        n_csel    = r_csel;
        n_cf      = r_cf;
        n_cup     = r_cup;
        n_scar    = r_scar;
        n_who     = r_who;
        n_outcome = r_outcome;
        n_pos     = r_pos;
        n_tgt     = r_tgt;
        n_dir     = r_dir;
        n_busy    = r_busy;
        n_mask    = r_mask;
        n_armed   = r_armed;

        w_tbl_req.op    = TBL_NONE;
        w_tbl_req.car   = r_scar;
        w_tbl_req.up    = 1'b0;
        w_tbl_req.floor = w_scan_idx;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_csel    = i_car_sel;
                    n_cf      = i_call_floor;
                    n_cup     = i_going_up;
                    n_who     = 1'b0;
                    n_outcome = OUT_IGNORED;
                end
            end
            S_CALL: begin
                if (!w_out_range) begin
                    n_who     = w_car;
                    n_outcome = OUT_QUEUED;
                    if (w_busy && w_pass) begin
                        n_mask[w_car][w_cf_idx] = 1'b1;
                        n_outcome               = OUT_PASSING;
                    end else begin
                        w_tbl_req.op    = TBL_INC;
                        w_tbl_req.car   = w_car;
                        w_tbl_req.up    = r_cup;
                        w_tbl_req.floor = r_cf;
                        if (!w_busy) begin
                            n_dir[w_car] = r_cup ? DIR_UP : DIR_DN;
                            n_scar       = w_car;
                        end
                    end
                end
            end
            S_TICK: begin
                if (w_busy) begin
                    if (w_stop) begin
                        n_mask[w_car][w_pos_idx] = 1'b0;
                        n_outcome                = OUT_PAUSED;
                    end else if (w_pos == w_tgt) begin
                        n_busy[w_car] = 1'b0;
                        n_scar        = w_car;
                        n_outcome     = OUT_REACHED;
                    end else begin
                        n_pos[w_car] = (w_tgt > w_pos) ? (w_pos + 1'b1) : (w_pos - 1'b1);
                        n_outcome    = OUT_MOVED;
                    end
                end
            end
            S_EXP: begin
                // an expiry always disarms its car
                n_armed[w_car] = 1'b0;
                n_scar         = w_car;
            end
            S_XCHK: begin
                // no pending calls: issue a down call at the home floor
                n_cf  = w_car ? r_home_b : r_home_a;
                n_cup = 1'b0;
            end
            S_PICK: begin
                n_armed[w_car] = 1'b0;
                if (w_empty) begin
                    n_busy[w_car]  = 1'b0;
                    n_dir[w_car]   = DIR_IDLE;
                    n_armed[w_car] = 1'b1;
                end else begin
                    w_tbl_req.op    = TBL_DEC;
                    w_tbl_req.car   = w_car;
                    w_tbl_req.up    = w_pick_up;
                    w_tbl_req.floor = w_pick_f;
                    n_tgt[w_car]    = w_pick_f;
                    n_busy[w_car]   = 1'b1;
                    n_dir[w_car]    = w_pick_up ? DIR_UP : DIR_DN;
                end
            end
            default: begin
                n_outcome = r_outcome;
            end
        endcase
    end

    // control and car state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pos[0]   <= RST_POS_A;
            r_pos[1]   <= RST_POS_B;
            r_tgt      <= '{default: '0};
            r_dir      <= '{default: DIR_IDLE};
            r_busy     <= '{default: 1'b0};
            r_mask     <= '{default: '0};
            r_armed    <= '{default: 1'b0};
            r_split    <= SPLIT_RST;
            r_home_a   <= HOME_A_RST;
            r_home_b   <= HOME_B_RST;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_tgt   <= n_tgt;
            r_dir   <= n_dir;
            r_busy  <= n_busy;
            r_mask  <= n_mask;
            r_armed <= n_armed;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_SPLIT:  r_split  <= i_cfg_wdata;
                    CFG_HOME_A: r_home_a <= i_cfg_wdata;
                    CFG_HOME_B: r_home_b <= i_cfg_wdata;
                    default:    r_split  <= r_split;
                endcase
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        r_csel    <= n_csel;
        r_cf      <= n_cf;
        r_cup     <= n_cup;
        r_scar    <= n_scar;
        r_who     <= n_who;
        r_outcome <= n_outcome;
    end

    // handshake and result ports
    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = (r_state == S_DONE);
    assign o_car_a_floor   = r_pos[0];
    assign o_car_b_floor   = r_pos[1];
    assign o_car_a_target  = r_tgt[0];
    assign o_car_b_target  = r_tgt[1];
    assign o_car_a_moving  = r_busy[0];
    assign o_car_b_moving  = r_busy[1];
    assign o_car_a_heading = r_dir[0];
    assign o_car_b_heading = r_dir[1];
    assign o_assigned_car  = r_who;
    assign o_outcome       = r_outcome;

endmodule

`default_nettype wire

// ===== src/tced_tables.sv =====
// per-car up and down call count tables with saturating increment and plain decrement
`default_nettype none

module tced_tables #(
    parameter int NUM_FLOORS  = 9,
    parameter int COUNT_WIDTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tced_pkg::t_tbl_req i_req,
    output tced_pkg::t_tbl_rsp o_rsp
);
    import tced_pkg::*;

    localparam int FIDX_W = (NUM_FLOORS > 1) ? $clog2(NUM_FLOORS) : 1;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] r_up_cnt [2][NUM_FLOORS];
    logic [COUNT_WIDTH-1:0] r_dn_cnt [2][NUM_FLOORS];

    logic [FIDX_W-1:0]      w_fidx;
    logic [COUNT_WIDTH-1:0] w_up_rd;
    logic [COUNT_WIDTH-1:0] w_dn_rd;
    logic [COUNT_WIDTH-1:0] w_sel;
    logic [COUNT_WIDTH-1:0] n_sel;
    logic                   w_wr;

    // read both tables at the requested car and floor
    assign w_fidx  = i_req.floor[FIDX_W-1:0];
    assign w_up_rd = r_up_cnt[i_req.car][w_fidx];
    assign w_dn_rd = r_dn_cnt[i_req.car][w_fidx];

    assign o_rsp.up_nz = |w_up_rd;
    assign o_rsp.dn_nz = |w_dn_rd;

    // update of the selected entry
    always_comb begin
        w_sel = i_req.up ? w_up_rd : w_dn_rd;
        n_sel = w_sel;
        w_wr  = 1'b0;
        case (i_req.op)
            TBL_INC: begin
                if (w_sel != CNT_MAX) begin
                    n_sel = w_sel + 1'b1;
                    w_wr  = 1'b1;
                end
            end
            TBL_DEC: begin
                n_sel = w_sel - 1'b1;
                w_wr  = 1'b1;
            end
            default: begin
                w_wr = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < 2; c++) begin
                for (int f = 0; f < NUM_FLOORS; f++) begin
                    r_up_cnt[c][f] <= '0;
                    r_dn_cnt[c][f] <= '0;
                end
            end
        end else if (w_wr) begin
            if (i_req.up) begin
                r_up_cnt[i_req.car][w_fidx] <= n_sel;
            end else begin
                r_dn_cnt[i_req.car][w_fidx] <= n_sel;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/tced_scan.sv =====
// floor scan unit: walks one floor per cycle and finds the next pending targets
`default_nettype none

module tced_scan #(
    parameter int NUM_FLOORS = 9
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tced_pkg::t_scan_ctl i_ctl,
    input  tced_pkg::t_tbl_rsp  i_rsp,
    output tced_pkg::t_floor    o_idx,
    output logic                o_last,
    output tced_pkg::t_scan_res o_res
);
    import tced_pkg::*;

    localparam t_floor LAST_IDX = FLOOR_W'(NUM_FLOORS - 1);

    t_floor    r_idx;
    t_floor    n_idx;
    t_scan_res r_res;
    t_scan_res n_res;

    // first up hit is the lowest, last down hit is the highest
    always_comb begin
        n_idx = r_idx;
        n_res = r_res;
        if (i_ctl.start) begin
            n_idx = '0;
            n_res = '0;
        end else if (i_ctl.step) begin
            if (i_rsp.up_nz && !r_res.up_hit) begin
                n_res.up_hit   = 1'b1;
                n_res.up_floor = r_idx;
            end
            if (i_rsp.dn_nz) begin
                n_res.dn_hit   = 1'b1;
                n_res.dn_floor = r_idx;
            end
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_res <= '0;
        end else begin
            r_idx <= n_idx;
            r_res <= n_res;
        end
    end

    assign o_idx  = r_idx;
    assign o_last = (r_idx == LAST_IDX);
    assign o_res  = r_res;

endmodule

`default_nettype wire

// ===== src/tced_checker.sv =====
// port-level checks of the two-car elevator dispatcher and their bind
`default_nettype none

module tced_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_ready,
    input logic                o_valid,
    input logic                i_ready,
    input tced_pkg::t_floor    o_car_a_floor,
    input tced_pkg::t_floor    o_car_b_floor,
    input logic                o_car_a_moving,
    input logic                o_car_b_moving,
    input logic signed [1:0]   o_car_a_heading,
    input logic signed [1:0]   o_car_b_heading,
    input logic                o_assigned_car,
    input logic [2:0]          o_outcome
);
    import tced_pkg::*;

    // one request in flight: never ready while a result waits
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("ready and result valid together");

    // a transfer in closes the request side
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("still ready after request transfer");

    // at each result a moving car has a heading, an idle one has none
    a_heading_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_car_a_moving == (o_car_a_heading != DIR_IDLE)) &&
                     (o_car_b_moving == (o_car_b_heading != DIR_IDLE))))
        else $error("heading does not match moving flag");

    // an ignored request names no car
    a_ignored_no_car: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_outcome == OUT_IGNORED)) |-> !o_assigned_car)
        else $error("ignored request reports a car");

    // stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_outcome) &&
            $stable(o_assigned_car) && $stable(o_car_a_floor) && $stable(o_car_b_floor)))
        else $error("stalled result changed");

endmodule

bind two_car_elevator_dispatcher tced_checker u_tced_checker (.*);

`default_nettype wire

// ===== sim/tb_two_car_elevator_dispatcher.sv =====
// self-checking testbench for the two-car elevator dispatcher
module tb_two_car_elevator_dispatcher;
    timeunit 1ns;
    timeprecision 1ps;

    import tced_pkg::*;

    localparam int NF            = 9;
    localparam int CNT_MAX       = 15;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int SETTLE_CYCLES = 30;
    localparam int SEG_ITEMS     = 112;
    localparam int NUM_SEGS      = 6;
    localparam int HOLD_AT       = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    // register settings and idle mode of each random segment
    localparam t_floor SEG_SPLIT  [NUM_SEGS] = '{4'd4, 4'd0, 4'd15, 4'd8, 4'd2, 4'd6};
    localparam t_floor SEG_HOME_A [NUM_SEGS] = '{4'd1, 4'd0, 4'd8, 4'd15, 4'd3, 4'd8};
    localparam t_floor SEG_HOME_B [NUM_SEGS] = '{4'd6, 4'd8, 4'd0, 4'd12, 4'd7, 4'd8};
    localparam int     SEG_MODE   [NUM_SEGS] = '{0, 0, 1, 1, 2, 2};

    typedef struct {
        logic [1:0] func;
        logic       car;
        t_floor     floor;
        logic       up;
    } t_request;

    typedef struct {
        t_floor     a_floor;
        t_floor     b_floor;
        t_floor     a_target;
        t_floor     b_target;
        logic       a_moving;
        logic       b_moving;
        logic [1:0] a_heading;
        logic [1:0] b_heading;
        logic       assigned;
        logic [2:0] outcome;
    } t_car_status;

    // dut signals
    logic             i_clk        = 1'b0;
    logic             i_rst_n      = 1'b0;
    logic             i_valid      = 1'b0;
    logic             o_ready;
    logic [1:0]       i_func       = FUNC_CALL;
    logic             i_car_sel    = 1'b0;
    t_floor           i_call_floor = '0;
    logic             i_going_up   = 1'b0;
    logic             o_valid;
    logic             i_ready      = 1'b0;
    t_floor           o_car_a_floor;
    t_floor           o_car_b_floor;
    t_floor           o_car_a_target;
    t_floor           o_car_b_target;
    logic             o_car_a_moving;
    logic             o_car_b_moving;
    logic signed [1:0] o_car_a_heading;
    logic signed [1:0] o_car_b_heading;
    logic             o_assigned_car;
    logic [2:0]       o_outcome;
    logic             i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_addr = CFG_SPLIT;
    t_floor           i_cfg_wdata  = '0;

    // testbench bookkeeping
    t_request    request_q [$];
    t_car_status status_due_q [$];
    t_request    cur_req;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_left     = 0;
    int          err_cnt       = 0;
    int          items_sent    = 0;
    int          results_seen  = 0;
    int          outcome_seen [6] = '{0, 0, 0, 0, 0, 0};
    int          cycle_cnt     = 0;

    // dispatcher state as predicted
    t_floor            split_m;
    t_floor            home_m [2];
    int                pos_m [2];
    int                tgt_m [2];
    logic signed [1:0] dir_m [2];
    bit                busy_m [2];
    bit                armed_m [2];
    int                up_cnt [2][NF];
    int                dn_cnt [2][NF];
    bit [NF-1:0]       stops_m [2];

    two_car_elevator_dispatcher #(
        .NUM_FLOORS  (NF),
        .COUNT_WIDTH (4)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_car_sel       (i_car_sel),
        .i_call_floor    (i_call_floor),
        .i_going_up      (i_going_up),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_car_a_floor   (o_car_a_floor),
        .o_car_b_floor   (o_car_b_floor),
        .o_car_a_target  (o_car_a_target),
        .o_car_b_target  (o_car_b_target),
        .o_car_a_moving  (o_car_a_moving),
        .o_car_b_moving  (o_car_b_moving),
        .o_car_a_heading (o_car_a_heading),
        .o_car_b_heading (o_car_b_heading),
        .o_assigned_car  (o_assigned_car),
        .o_outcome       (o_outcome),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int clamp_floor(int f);
        return (f < NF) ? f : NF - 1;
    endfunction

    function automatic void reset_cars();
        split_m   = SPLIT_RST;
        home_m[0] = HOME_A_RST;
        home_m[1] = HOME_B_RST;
        pos_m[0]  = clamp_floor(HOME_A_RST);
        pos_m[1]  = clamp_floor(HOME_B_RST);
        for (int c = 0; c < 2; c++) begin
            tgt_m[c]   = 0;
            dir_m[c]   = DIR_IDLE;
            busy_m[c]  = 1'b0;
            armed_m[c] = 1'b0;
            stops_m[c] = '0;
            for (int f = 0; f < NF; f++) begin
                up_cnt[c][f] = 0;
                dn_cnt[c][f] = 0;
            end
        end
    endfunction

    function automatic bit tables_idle(int c);
        for (int f = 0; f < NF; f++)
            if (up_cnt[c][f] != 0 || dn_cnt[c][f] != 0)
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic int lowest_up(int c);
        for (int f = 0; f < NF; f++)
            if (up_cnt[c][f] != 0)
                return f;
        return -1;
    endfunction

    function automatic int highest_down(int c);
        for (int f = NF - 1; f >= 0; f--)
            if (dn_cnt[c][f] != 0)
                return f;
        return -1;
    endfunction

    // next target from the car's tables, reversing when the heading table is empty
    function automatic void pick_target(int c);
        int f;
        armed_m[c] = 1'b0;
        if (tables_idle(c)) begin
            busy_m[c]  = 1'b0;
            dir_m[c]   = DIR_IDLE;
            armed_m[c] = 1'b1;
            return;
        end
        if (dir_m[c] == DIR_UP) begin
            f = lowest_up(c);
            if (f >= 0) begin
                up_cnt[c][f]--;
            end else begin
                dir_m[c] = DIR_DN;
                f = highest_down(c);
                dn_cnt[c][f]--;
            end
        end else begin
            f = highest_down(c);
            if (f >= 0) begin
                dn_cnt[c][f]--;
            end else begin
                dir_m[c] = DIR_UP;
                f = lowest_up(c);
                up_cnt[c][f]--;
            end
        end
        tgt_m[c]  = f;
        busy_m[c] = 1'b1;
    endfunction

    // saturating call count
    function automatic void log_call(int c, int f, bit up);
        if (up) begin
            if (up_cnt[c][f] < CNT_MAX) up_cnt[c][f]++;
        end else begin
            if (dn_cnt[c][f] < CNT_MAX) dn_cnt[c][f]++;
        end
    endfunction

    function automatic t_outcome dispatch_call(int f, bit up, output int who);
        int da;
        int db;
        int c;
        who = 0;
        if (f >= NF)
            return OUT_IGNORED;
        da = (pos_m[0] > f) ? pos_m[0] - f : f - pos_m[0];
        db = (pos_m[1] > f) ? pos_m[1] - f : f - pos_m[1];
        c  = (f <= split_m) ? 0 : 1;
        // preferred car busy: the idle one, else the nearer one with ties to car A
        if (busy_m[c]) begin
            if (!busy_m[0] && busy_m[1])
                c = 0;
            else if (busy_m[0] && !busy_m[1])
                c = 1;
            else
                c = (da <= db) ? 0 : 1;
        end
        who = c;
        if (busy_m[c]) begin
            if ((dir_m[c] == DIR_UP && up && f > pos_m[c] && f < tgt_m[c]) ||
                (dir_m[c] == DIR_DN && !up && f < pos_m[c] && f > tgt_m[c])) begin
                stops_m[c][f] = 1'b1;
                return OUT_PASSING;
            end
            log_call(c, f, up);
            return OUT_QUEUED;
        end
        log_call(c, f, up);
        dir_m[c] = up ? DIR_UP : DIR_DN;
        pick_target(c);
        return OUT_QUEUED;
    endfunction

    function automatic t_outcome move_car(int c);
        int p;
        p = pos_m[c];
        if (!busy_m[c])
            return OUT_IGNORED;
        if (p < NF && stops_m[c][p]) begin
            stops_m[c][p] = 1'b0;
            return OUT_PAUSED;
        end
        if (p == tgt_m[c]) begin
            busy_m[c] = 1'b0;
            pick_target(c);
            return OUT_REACHED;
        end
        pos_m[c] = (tgt_m[c] > p) ? p + 1 : p - 1;
        return OUT_MOVED;
    endfunction

    // car status after one request
    function automatic t_car_status next_car_status(t_request r);
        t_car_status s;
        t_outcome    res;
        int          who;
        int          c;
        bit          armed;
        res = OUT_IGNORED;
        who = 0;
        c   = r.car;
        case (r.func)
            FUNC_CALL: begin
                res = dispatch_call(r.floor, r.up, who);
            end
            FUNC_TICK: begin
                res = move_car(c);
            end
            FUNC_EXPIRE: begin
                armed      = armed_m[c];
                armed_m[c] = 1'b0;
                if (armed && !busy_m[c] && dir_m[c] == DIR_IDLE && tables_idle(c))
                    res = dispatch_call(home_m[c], 1'b0, who);
            end
            default: ;
        endcase
        if (res == OUT_IGNORED)
            who = 0;
        s.a_floor   = t_floor'(pos_m[0]);
        s.b_floor   = t_floor'(pos_m[1]);
        s.a_target  = t_floor'(tgt_m[0]);
        s.b_target  = t_floor'(tgt_m[1]);
        s.a_moving  = busy_m[0];
        s.b_moving  = busy_m[1];
        s.a_heading = dir_m[0];
        s.b_heading = dir_m[1];
        s.assigned  = who[0];
        s.outcome   = res;
        return s;
    endfunction

    function automatic t_request rand_request(logic [1:0] func);
        t_request r;
        r.func  = func;
        r.car   = 1'($urandom_range(1));
        r.floor = 4'($urandom_range(15));
        r.up    = 1'($urandom_range(1));
        return r;
    endfunction

    function automatic t_request make_request(logic [1:0] func, logic car, int f, logic up);
        t_request r;
        r.func  = func;
        r.car   = car;
        r.floor = 4'(f);
        r.up    = up;
        return r;
    endfunction

    // a burst of calls, ticks to serve them, maybe an idle-return expiry and a spare code
    function automatic void queue_episode();
        t_request r;
        int       n;
        n = $urandom_range(3, 1);
        repeat (n) begin
            r = rand_request(FUNC_CALL);
            r.floor = ($urandom_range(7) == 0) ? 4'($urandom_range(15, NF)) :
                                                 4'($urandom_range(NF - 1));
            request_q.push_back(r);
        end
        n = $urandom_range(24, 4);
        repeat (n) request_q.push_back(rand_request(FUNC_TICK));
        if ($urandom_range(1) == 1)
            request_q.push_back(rand_request(FUNC_EXPIRE));
        if ($urandom_range(9) == 0)
            request_q.push_back(rand_request(FUNC_SPARE));
    endfunction

    function automatic void set_idle_mode(int mode);
        case (mode)
            0: begin send_idle_pct = 11; recv_idle_pct = 60; end
            1: begin send_idle_pct = 60; recv_idle_pct = 11; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
        endcase
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, t_floor val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SPLIT)
            split_m = val;
        else if (idx == CFG_HOME_A)
            home_m[0] = val;
        else
            home_m[1] = val;
    endtask

    // block until every queued request has been sent and answered
    task automatic wait_drained();
        do @(negedge i_clk);
        while (request_q.size() != 0 || i_valid || status_due_q.size() != 0);
    endtask

    // request driver: predicts each transfer and presents the next request
    always @(posedge i_clk) begin : drive_requests
        bit          holding;
        t_car_status due;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            holding = i_valid;
            if (i_valid && o_ready) begin
                due = next_car_status(cur_req);
                status_due_q.push_back(due);
                items_sent++;
                holding = 1'b0;
            end
            if (!holding) begin
                if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_req      = request_q.pop_front();
                    i_func       <= cur_req.func;
                    i_car_sel    <= cur_req.car;
                    i_call_floor <= cur_req.floor;
                    i_going_up   <= cur_req.up;
                    i_valid      <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random and long stalls
    always @(posedge i_clk) begin : check_results
        t_car_status due;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (status_due_q.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual outcome %0d",
                             $time, o_outcome);
                    err_cnt++;
                end else begin
                    due = status_due_q.pop_front();
                    check_field("car_a_floor", due.a_floor, o_car_a_floor);
                    check_field("car_b_floor", due.b_floor, o_car_b_floor);
                    check_field("car_a_target", due.a_target, o_car_a_target);
                    check_field("car_b_target", due.b_target, o_car_b_target);
                    check_field("car_a_moving", due.a_moving, o_car_a_moving);
                    check_field("car_b_moving", due.b_moving, o_car_b_moving);
                    check_field("car_a_heading", due.a_heading, $unsigned(o_car_a_heading));
                    check_field("car_b_heading", due.b_heading, $unsigned(o_car_b_heading));
                    check_field("assigned_car", due.assigned, o_assigned_car);
                    check_field("outcome", due.outcome, o_outcome);
                end
                if (o_outcome < 6)
                    outcome_seen[o_outcome]++;
                results_seen++;
                if (results_seen == HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t ns: run limit reached with %0d results outstanding",
                     $time, status_due_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    // stimulus sequence
    initial begin
        reset_cars();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        set_idle_mode(0);

        // directed: ignored requests, both cars dispatched, passing stops, table saturation
        request_q.push_back(make_request(FUNC_SPARE, 1'b1, 15, 1'b1));
        request_q.push_back(make_request(FUNC_TICK, 1'b0, 0, 1'b0));
        request_q.push_back(make_request(FUNC_EXPIRE, 1'b1, 0, 1'b0));
        request_q.push_back(make_request(FUNC_CALL, 1'b0, 15, 1'b1));
        request_q.push_back(make_request(FUNC_CALL, 1'b1, 9, 1'b0));
        request_q.push_back(make_request(FUNC_CALL, 1'b0, 0, 1'b0));
        request_q.push_back(make_request(FUNC_CALL, 1'b1, 8, 1'b1));
        request_q.push_back(make_request(FUNC_CALL, 1'b0, 7, 1'b1));
        request_q.push_back(make_request(FUNC_CALL, 1'b0, 7, 1'b1));
        repeat (CNT_MAX + 1)
            request_q.push_back(make_request(FUNC_CALL, 1'b0, 0, 1'b1));
        wait_drained();

        // random segments, each under its own register setting
        for (int s = 0; s < NUM_SEGS; s++) begin
            write_cfg(CFG_SPLIT, SEG_SPLIT[s]);
            write_cfg(CFG_HOME_A, SEG_HOME_A[s]);
            write_cfg(CFG_HOME_B, SEG_HOME_B[s]);
            @(negedge i_clk);
            set_idle_mode(SEG_MODE[s]);
            while (request_q.size() < SEG_ITEMS)
                queue_episode();
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Run: %0d requests sent, %0d results checked, %0d mismatches",
                 items_sent, results_seen, err_cnt);
        $display("Outcomes: ignored %0d, queued %0d, passing %0d, moved %0d, paused %0d, reached %0d",
                 outcome_seen[0], outcome_seen[1], outcome_seen[2],
                 outcome_seen[3], outcome_seen[4], outcome_seen[5]);
        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/tced_pkg.sv
src/tced_tables.sv
src/tced_scan.sv
src/two_car_elevator_dispatcher.sv
src/tced_checker.sv
sim/tb_two_car_elevator_dispatcher.sv
